>>> rtl/core/tun_pkg.sv
`timescale 1ns / 1ps

package tun_pkg;

  localparam int COORD_W = 24;
  localparam int NORM_W  = 16;
  localparam int FRAC    = NORM_W - 2;
  localparam int QB      = FRAC + 1;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int C_W     = PROD_W + 1;
  localparam int CMAG_W  = 2 * COORD_W + 2;
  localparam int LO_W    = CMAG_W / 2;
  localparam int HI_W    = CMAG_W - LO_W;
  localparam int SQ_W    = 2 * CMAG_W;
  localparam int LEN_W   = SQ_W + 2;
  localparam int ACC_W   = LEN_W + 2 * FRAC + 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [LEN_W-1:0]       len2;
    logic [2:0][SQ_W-1:0]   sq;
    logic [2:0]             neg;
    logic                   deg;
  } mid_t;

endpackage

>>> rtl/core/tun_front.sv
`timescale 1ns / 1ps

module tun_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [tun_pkg::COORD_W-1:0]      first_x,
  input  logic [tun_pkg::COORD_W-1:0]      first_y,
  input  logic [tun_pkg::COORD_W-1:0]      first_z,
  input  logic [tun_pkg::COORD_W-1:0]      second_x,
  input  logic [tun_pkg::COORD_W-1:0]      second_y,
  input  logic [tun_pkg::COORD_W-1:0]      second_z,
  input  logic [tun_pkg::COORD_W-1:0]      third_x,
  input  logic [tun_pkg::COORD_W-1:0]      third_y,
  input  logic [tun_pkg::COORD_W-1:0]      third_z,
  output logic                             item_vld,
  output tun_pkg::mid_t                    item,
  input  logic                             q_full
);

  logic en;
  logic [6:1] vld_r;
  logic [6:1] vld_nxt;

  // stage 1: edge vectors
  logic signed [tun_pkg::DIFF_W-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  // stage 2: cross product terms
  logic signed [tun_pkg::PROD_W-1:0] p_r [0:2];
  logic signed [tun_pkg::PROD_W-1:0] m_r [0:2];
  // stage 3: magnitude and sign
  logic [tun_pkg::CMAG_W-1:0] mag_r [0:2];
  logic [2:0] neg3_r;
  // stage 4: square partials
  logic [2*tun_pkg::HI_W-1:0]            hh_r [0:2];
  logic [tun_pkg::HI_W+tun_pkg::LO_W-1:0] hl_r [0:2];
  logic [2*tun_pkg::LO_W-1:0]            ll_r [0:2];
  logic [2:0] neg4_r, nz4_r;
  // stage 5: squares
  logic [tun_pkg::SQ_W-1:0] sq_r [0:2];
  logic [2:0] neg5_r, nz5_r;
  // stage 6: queue item
  tun_pkg::mid_t item_r;

  logic signed [tun_pkg::C_W-1:0] c_s [0:2];

  function automatic logic signed [tun_pkg::DIFF_W-1:0] sdiff(
    input logic [tun_pkg::COORD_W-1:0] x,
    input logic [tun_pkg::COORD_W-1:0] y
  );
    sdiff = $signed({x[tun_pkg::COORD_W-1], x}) - $signed({y[tun_pkg::COORD_W-1], y});
  endfunction

  assign en   = !(vld_r[6] && q_full);
  assign full = !en;

  always_comb begin
    vld_nxt = {vld_r[5:1], push && en};
    for (int i = 0; i < 3; i++) begin
      c_s[i] = tun_pkg::C_W'(p_r[i]) - tun_pkg::C_W'(m_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= sdiff(first_x, second_x);
      ay_r <= sdiff(first_y, second_y);
      az_r <= sdiff(first_z, second_z);
      bx_r <= sdiff(first_x, third_x);
      by_r <= sdiff(first_y, third_y);
      bz_r <= sdiff(first_z, third_z);

      p_r[0] <= ay_r * bz_r;
      m_r[0] <= by_r * az_r;
      p_r[1] <= bx_r * az_r;
      m_r[1] <= ax_r * bz_r;
      p_r[2] <= ax_r * by_r;
      m_r[2] <= bx_r * ay_r;

      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= c_s[i][tun_pkg::C_W-1] ? tun_pkg::CMAG_W'(-c_s[i])
                                            : tun_pkg::CMAG_W'(c_s[i]);
        neg3_r[i] <= c_s[i][tun_pkg::C_W-1];

        hh_r[i]  <= mag_r[i][tun_pkg::CMAG_W-1:tun_pkg::LO_W] *
                    mag_r[i][tun_pkg::CMAG_W-1:tun_pkg::LO_W];
        hl_r[i]  <= mag_r[i][tun_pkg::CMAG_W-1:tun_pkg::LO_W] *
                    mag_r[i][tun_pkg::LO_W-1:0];
        ll_r[i]  <= mag_r[i][tun_pkg::LO_W-1:0] * mag_r[i][tun_pkg::LO_W-1:0];
        neg4_r[i] <= neg3_r[i];
        nz4_r[i]  <= |mag_r[i];

        sq_r[i]  <= (tun_pkg::SQ_W'(hh_r[i]) << (2 * tun_pkg::LO_W)) +
                    (tun_pkg::SQ_W'(hl_r[i]) << (tun_pkg::LO_W + 1)) +
                    tun_pkg::SQ_W'(ll_r[i]);
        neg5_r[i] <= neg4_r[i];
        nz5_r[i]  <= nz4_r[i];

        item_r.sq[i] <= sq_r[i];
      end
      item_r.len2 <= tun_pkg::LEN_W'(sq_r[0]) + tun_pkg::LEN_W'(sq_r[1]) +
                     tun_pkg::LEN_W'(sq_r[2]);
      item_r.neg  <= neg5_r;
      item_r.deg  <= ~|nz5_r;
    end
  end

  assign item_vld = vld_r[6];
  assign item     = item_r;

endmodule

>>> rtl/core/tun_queue.sv
`timescale 1ns / 1ps

module tun_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tun_pkg::mid_t push_item,
  input  logic          pop,
  output tun_pkg::mid_t head,
  output logic          empty,
  output logic          full
);

  tun_pkg::mid_t mem_r [0:tun_pkg::Q_DEPTH-1];
  logic [tun_pkg::Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [tun_pkg::Q_CW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == tun_pkg::Q_CW'(tun_pkg::Q_DEPTH));
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + tun_pkg::Q_CW'(push) - tun_pkg::Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("queue lost a transfer");
`endif

endmodule

>>> rtl/core/tun_back.sv
`timescale 1ns / 1ps

module tun_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tun_pkg::mid_t             head,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [tun_pkg::NORM_W-1:0] normal_x,
  output logic [tun_pkg::NORM_W-1:0] normal_y,
  output logic [tun_pkg::NORM_W-1:0] normal_z,
  output logic                      degenerate
);

  localparam int LAST = tun_pkg::QB - 1;

  logic en;
  logic [tun_pkg::QB-1:0] vld_r;
  logic [tun_pkg::ACC_W-1:0] r_r [0:tun_pkg::QB-1][0:2];
  logic [tun_pkg::ACC_W-1:0] a_r [0:tun_pkg::QB-1][0:2];
  logic [tun_pkg::QB-1:0]    q_r [0:tun_pkg::QB-1][0:2];
  logic [tun_pkg::LEN_W-1:0] len_r [0:tun_pkg::QB-1];
  logic [2:0]                neg_r [0:tun_pkg::QB-1];
  logic                      deg_r [0:tun_pkg::QB-1];

  // two-entry result queue
  logic [tun_pkg::NORM_W-1:0] oq_n_r [0:1][0:2];
  logic                       oq_d_r [0:1];
  logic                       oq_wp_r, oq_rp_r;
  logic [1:0]                 oq_cnt_r;
  logic                       oq_full, oq_push, oq_pop;
  logic [tun_pkg::NORM_W-1:0] res_n [0:2];

  assign oq_full = (oq_cnt_r == 2'd2);
  assign en      = !(vld_r[LAST] && oq_full);
  assign q_pop   = en && !q_empty;
  assign oq_push = en && vld_r[LAST];
  assign oq_pop  = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], q_pop};
    end
  end

  // one quotient bit per stage, MSB first; remainder R = c^2*2^2F - q^2*len2
  for (genvar k = 0; k < tun_pkg::QB; k++) begin : g_stage
    localparam int J = tun_pkg::FRAC - k;
    logic [tun_pkg::ACC_W-1:0] r_s [0:2];
    logic [tun_pkg::ACC_W-1:0] a_s [0:2];
    logic [tun_pkg::QB-1:0]    q_s [0:2];
    logic [tun_pkg::LEN_W-1:0] len_s;
    logic [2:0]                neg_s;
    logic                      deg_s;
    logic [tun_pkg::ACC_W-1:0] t_s [0:2];

    always_comb begin
      if (k == 0) begin
        for (int i = 0; i < 3; i++) begin
          r_s[i] = tun_pkg::ACC_W'(head.sq[i]) << (2 * tun_pkg::FRAC);
          a_s[i] = '0;
          q_s[i] = '0;
        end
        len_s = head.len2;
        neg_s = head.neg;
        deg_s = head.deg;
      end else begin
        for (int i = 0; i < 3; i++) begin
          r_s[i] = r_r[(k == 0) ? 0 : k - 1][i];
          a_s[i] = a_r[(k == 0) ? 0 : k - 1][i];
          q_s[i] = q_r[(k == 0) ? 0 : k - 1][i];
        end
        len_s = len_r[(k == 0) ? 0 : k - 1];
        neg_s = neg_r[(k == 0) ? 0 : k - 1];
        deg_s = deg_r[(k == 0) ? 0 : k - 1];
      end
      for (int i = 0; i < 3; i++) begin
        t_s[i] = (a_s[i] << (J + 1)) + (tun_pkg::ACC_W'(len_s) << (2 * J));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (t_s[i] <= r_s[i]) begin
            r_r[k][i] <= r_s[i] - t_s[i];
            a_r[k][i] <= a_s[i] + (tun_pkg::ACC_W'(len_s) << J);
            q_r[k][i] <= q_s[i] | (tun_pkg::QB'(1) << J);
          end else begin
            r_r[k][i] <= r_s[i];
            a_r[k][i] <= a_s[i];
            q_r[k][i] <= q_s[i];
          end
        end
        len_r[k] <= len_s;
        neg_r[k] <= neg_s;
        deg_r[k] <= deg_s;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (deg_r[LAST]) begin
        res_n[i] = '0;
      end else if (neg_r[LAST][i]) begin
        res_n[i] = -tun_pkg::NORM_W'(q_r[LAST][i]);
      end else begin
        res_n[i] = tun_pkg::NORM_W'(q_r[LAST][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      oq_wp_r  <= oq_wp_r ^ oq_push;
      oq_rp_r  <= oq_rp_r ^ oq_pop;
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      for (int i = 0; i < 3; i++) begin
        oq_n_r[oq_wp_r][i] <= res_n[i];
      end
      oq_d_r[oq_wp_r] <= deg_r[LAST];
    end
  end

  assign out_empty  = (oq_cnt_r == '0);
  assign normal_x   = oq_n_r[oq_rp_r][0];
  assign normal_y   = oq_n_r[oq_rp_r][1];
  assign normal_z   = oq_n_r[oq_rp_r][2];
  assign degenerate = oq_d_r[oq_rp_r];

endmodule

>>> rtl/core/triangle_unit_normal_core.sv
`timescale 1ns / 1ps

// Unit face normal of a triangle.
// Input channel: in_push / in_full. Each transfer carries three vertices in
// signed Q8.16. Result channel: out_empty / out_pop. Each result carries the
// unit normal in signed Q2.14 (rounded toward zero) and a degenerate flag;
// a degenerate triangle (zero cross product) gives a zero vector, flag set.
// One result per input, in input order.
// Throughput: one triangle per cycle unless stalled. The front end (edges,
// cross product, squares, squared length) is a 6-stage pipeline; the back
// end resolves one quotient bit per stage over 15 stages, so both sustain
// one item a cycle. A 4-entry queue between the two lets each stall on its
// own. Receiver stall: results collect in a 2-entry output queue; when it
// is full the back end halts, the middle queue fills, then the front end
// halts and in_full rises. No item is dropped.
// Reset (rst_n low, synchronous) empties all pipelines and queues.

module triangle_unit_normal_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [tun_pkg::COORD_W-1:0] in_first_x,
  input  logic [tun_pkg::COORD_W-1:0] in_first_y,
  input  logic [tun_pkg::COORD_W-1:0] in_first_z,
  input  logic [tun_pkg::COORD_W-1:0] in_second_x,
  input  logic [tun_pkg::COORD_W-1:0] in_second_y,
  input  logic [tun_pkg::COORD_W-1:0] in_second_z,
  input  logic [tun_pkg::COORD_W-1:0] in_third_x,
  input  logic [tun_pkg::COORD_W-1:0] in_third_y,
  input  logic [tun_pkg::COORD_W-1:0] in_third_z,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [tun_pkg::NORM_W-1:0] out_normal_x,
  output logic [tun_pkg::NORM_W-1:0] out_normal_y,
  output logic [tun_pkg::NORM_W-1:0] out_normal_z,
  output logic                       out_degenerate
);

  tun_pkg::mid_t f_item;   // front end result
  tun_pkg::mid_t q_head;   // oldest queued item
  logic f_vld;
  logic q_full, q_empty, q_pop;
  logic q_push;

  tun_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .first_z  (in_first_z),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .second_z (in_second_z),
    .third_x  (in_third_x),
    .third_y  (in_third_y),
    .third_z  (in_third_z),
    .item_vld (f_vld),
    .item     (f_item),
    .q_full   (q_full)
  );

  // a front end item enters the queue only when the queue has room
  assign q_push = f_vld && !q_full;

  tun_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tun_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .normal_x   (out_normal_x),
    .normal_y   (out_normal_y),
    .normal_z   (out_normal_z),
    .degenerate (out_degenerate)
  );

endmodule
